// ===== src/egbr_pkg.sv =====
package egbr_pkg;

  // Item kinds carried on in_tuser
  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_READ   = 3'd2,
    KIND_PEEK   = 3'd3,
    KIND_SKIP   = 3'd4,
    KIND_UE     = 3'd5,
    KIND_SE     = 3'd6,
    KIND_STATUS = 3'd7
  } kind_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_STEP = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_CODE = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CNT_W      = 6;

  localparam logic [CNT_W-1:0]   MAX_BITS   = 6'd32;
  localparam logic [VALUE_W-1:0] CODE_LIMIT = 32'hFFFF_FFFF;
  localparam logic [VALUE_W-1:0] SE_LIMIT   = 32'h8000_0000;

  // Stop bit plus trailing zeros of the last byte; a zero byte counts as eight.
  function automatic logic [3:0] trailing_bits(input logic [7:0] b);
    logic [3:0] res;
    res = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) res = 4'(i + 1);
    end
    return res;
  endfunction

endpackage

// ===== src/egbr_ram.sv =====
module egbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem_r[rd_addr];
  end

endmodule

// ===== src/exp_golomb_bit_reader_top.sv =====
// Exp-Golomb bit reader: an MSB-first reader over a byte buffer held in RAM.
// Input channel (in_*): one item per command; in_tuser carries the kind
// (clear, append byte, read u(n), peek u(n), skip n, ue(v), se(v), status),
// in_tdata the byte to append and the bit count n (saturated to 32).
// Result channel (out_*): exactly one item per command, in order, carrying
// the value (bits read, ue codeNum or se value in two's complement) and the
// flags more_rbsp, aligned, at_end and code_too_long after the command.
// Throughput: one command at a time. The bit sequencer consumes one bit per
// cycle, except while a new byte under the read position is loaded through
// the registered RAM read. Clear, append and status go straight to the
// result step; read/peek/skip step through n bits; ue/se step through the
// zero prefix and the suffix bits, then add the code offset.
// Reset empties the buffer (length zero, position at bit 0 of byte 0); the
// RAM contents are not cleared, no clearing pass is needed.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and runs, and only its final step waits for the
// output register to drain.
module exp_golomb_bit_reader_top
  import egbr_pkg::*;
#(
  parameter int BUF_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte, [13:8] bit_count, [15:14] zero
  input  logic [KIND_W-1:0]     in_tuser,   // [2:0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [31:0] value, [32] more_rbsp, [33] aligned,
                                            // [34] at_end, [35] code_too_long, [39:36] zero
);

  localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int IW = $clog2(BUF_BYTES + 1);
  localparam logic [IW-1:0] BUF_LIMIT = IW'(BUF_BYTES);

  // Control state
  state_t            state_r, state_nxt;
  logic [IW-1:0]     len_r, len_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [3:0]        br_r, br_nxt;
  logic              cache_ok_r, cache_ok_nxt;
  logic              prefix_r, prefix_nxt;
  logic              too_long_r, too_long_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload state
  kind_t             kind_r, kind_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  zeros_r, zeros_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [IW-1:0]     save_idx_r, save_idx_nxt;
  logic [3:0]        save_br_r, save_br_nxt;
  logic [7:0]        cur_byte_r, cur_byte_nxt;
  logic [7:0]        last_byte_r, last_byte_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // RAM port
  logic       ram_wr_en;
  logic       ram_rd_en;
  logic [7:0] ram_rd_data;

  egbr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (len_r[AW-1:0]),
    .wr_data (in_tdata[7:0]),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Input decode
  kind_t            in_kind;
  logic [CNT_W-1:0] in_count;
  logic             in_accept;

  assign in_kind   = kind_t'(in_tuser);
  assign in_count  = (in_tdata[13] && (in_tdata[12:8] != 5'd0)) ? MAX_BITS : in_tdata[13:8];
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // One-bit take from the current position
  logic          in_buf, in_data, need_fetch, take_bit, crossed;
  logic [3:0]    br_dec;
  logic [IW-1:0] take_idx;
  logic [3:0]    take_br;
  logic          past_after;

  always_comb begin
    in_buf     = (idx_r < BUF_LIMIT);
    in_data    = (idx_r < len_r);
    need_fetch = in_buf && in_data && !cache_ok_r;
    br_dec     = br_r - 4'd1;
    take_bit   = in_data ? cur_byte_r[br_dec[2:0]] : 1'b0;
    crossed    = in_buf && (br_dec == 4'd0);
    if (!in_buf) begin
      take_idx = idx_r;
      take_br  = br_r;
    end else if (br_dec == 4'd0) begin
      take_idx = idx_r + IW'(1);
      take_br  = 4'd8;
    end else begin
      take_idx = idx_r;
      take_br  = br_dec;
    end
    past_after = (take_idx >= len_r);
  end

  // Result fields, from the position after the command
  logic [VALUE_W-1:0] res_value;
  logic [VALUE_W-1:0] k_half;
  logic               st_more, st_aligned, st_end;
  logic [IW:0]        idx_inc;

  always_comb begin
    k_half = acc_r >> 1;
    case (kind_r)
      KIND_READ, KIND_PEEK, KIND_UE: res_value = acc_r;
      KIND_SE:                       res_value = acc_r[0] ? (k_half + 32'd1) : (32'd0 - k_half);
      default:                       res_value = '0;
    endcase
    idx_inc    = {1'b0, idx_r} + {{IW{1'b0}}, 1'b1};
    st_aligned = (br_r == 4'd8);
    st_end     = (idx_r >= len_r);
    st_more    = (len_r != '0) && !st_end &&
                 ((idx_inc < {1'b0, len_r}) || (br_r > trailing_bits(last_byte_r)));
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    br_nxt        = br_r;
    cache_ok_nxt  = cache_ok_r;
    prefix_nxt    = prefix_r;
    too_long_nxt  = too_long_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    zeros_nxt     = zeros_r;
    acc_nxt       = acc_r;
    save_idx_nxt  = save_idx_r;
    save_br_nxt   = save_br_r;
    cur_byte_nxt  = cur_byte_r;
    last_byte_nxt = last_byte_r;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;

    // drain the output register
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          kind_nxt     = in_kind;
          cnt_nxt      = in_count;
          zeros_nxt    = '0;
          acc_nxt      = '0;
          too_long_nxt = 1'b0;
          prefix_nxt   = 1'b0;
          save_idx_nxt = idx_r;
          save_br_nxt  = br_r;
          state_nxt    = ST_FIN;
          unique case (in_kind)
            KIND_CLEAR: begin
              len_nxt      = '0;
              idx_nxt      = '0;
              br_nxt       = 4'd8;
              cache_ok_nxt = 1'b0;
            end
            KIND_APPEND: begin
              if (len_r < BUF_LIMIT) begin
                ram_wr_en     = 1'b1;
                len_nxt       = len_r + IW'(1);
                last_byte_nxt = in_tdata[7:0];
                cache_ok_nxt  = 1'b0;
              end
            end
            KIND_READ, KIND_PEEK, KIND_SKIP: state_nxt = ST_STEP;
            KIND_UE, KIND_SE: begin
              prefix_nxt = 1'b1;
              state_nxt  = ST_STEP;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      ST_STEP: begin
        if (prefix_r) begin
          if (need_fetch) begin
            ram_rd_en = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt      = take_idx;
            br_nxt       = take_br;
            cache_ok_nxt = cache_ok_r && !crossed;
            if (!take_bit && (zeros_r < MAX_BITS) && !past_after) begin
              zeros_nxt = zeros_r + CNT_W'(1);
            end else begin
              // prefix done: read a suffix of that many bits
              prefix_nxt = 1'b0;
              cnt_nxt    = zeros_r;
            end
          end
        end else if (cnt_r == '0) begin
          if (kind_r == KIND_PEEK) begin
            idx_nxt      = save_idx_r;
            br_nxt       = save_br_r;
            cache_ok_nxt = 1'b0;
          end
          state_nxt = ((kind_r == KIND_UE) || (kind_r == KIND_SE)) ? ST_CODE : ST_FIN;
        end else if (need_fetch) begin
          ram_rd_en = 1'b1;
          state_nxt = ST_LOAD;
        end else begin
          idx_nxt      = take_idx;
          br_nxt       = take_br;
          cache_ok_nxt = cache_ok_r && !crossed;
          acc_nxt      = {acc_r[VALUE_W-2:0], take_bit};
          cnt_nxt      = cnt_r - CNT_W'(1);
        end
      end

      ST_LOAD: begin
        cur_byte_nxt = ram_rd_data;
        cache_ok_nxt = 1'b1;
        state_nxt    = ST_STEP;
      end

      ST_CODE: begin
        if (zeros_r[CNT_W-1]) begin
          acc_nxt      = CODE_LIMIT;
          too_long_nxt = 1'b1;
        end else begin
          acc_nxt = acc_r + ~(CODE_LIMIT << zeros_r[4:0]);
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // hold here until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000, too_long_r, st_end, st_aligned, st_more, res_value};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      idx_r       <= '0;
      br_r        <= 4'd8;
      cache_ok_r  <= 1'b0;
      prefix_r    <= 1'b0;
      too_long_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      br_r        <= br_nxt;
      cache_ok_r  <= cache_ok_nxt;
      prefix_r    <= prefix_nxt;
      too_long_r  <= too_long_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    cnt_r       <= cnt_nxt;
    zeros_r     <= zeros_nxt;
    acc_r       <= acc_nxt;
    save_idx_r  <= save_idx_nxt;
    save_br_r   <= save_br_nxt;
    cur_byte_r  <= cur_byte_nxt;
    last_byte_r <= last_byte_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/egbr_checker.sv =====
module egbr_checker
  import egbr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // one command in flight: no accept right after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // more data implies the position is before the end
  a_more_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> !out_tdata[34])
    else $error("more_rbsp set at end of buffer");

  // overlong code yields the saturated ue or se value
  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[35]) |->
      ((out_tdata[31:0] == CODE_LIMIT) || (out_tdata[31:0] == SE_LIMIT)))
    else $error("code_too_long with unexpected value");

endmodule

bind exp_golomb_bit_reader_top egbr_checker u_egbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import egbr_pkg::*;

  localparam int DEPTH      = 4096;  // byte store size of the instance
  localparam int RAND_ITEMS = 800;   // rough size of the random part

  // One command as the sender sees it. When fixed is set, res is the result typed in
  // by hand and replaces the predicted one.
  typedef struct {
    kind_t                 kind;
    logic [7:0]            data;
    logic [5:0]            cnt;
    bit                    fixed;
    logic [OUT_DATA_W-1:0] res;
  } cmd_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [7:0] data_byte, [13:8] bit_count, [15:14] zero
  logic [KIND_W-1:0]     in_tuser   = '0;   // [2:0] kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [31:0] value, [32] more_rbsp, [33] aligned,
                                            // [34] at_end, [35] code_too_long, [39:36] zero

  exp_golomb_bit_reader_top #(
    .BUF_BYTES (DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hold reset low at the start, then release it once.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("[exp_golomb_bit_reader_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Bit reader mirror: byte store, fill length and read position.
  // ---------------------------------------------------------------------------
  logic [7:0]  rbsp_mem [DEPTH];
  int unsigned buf_len  = 0;
  int unsigned rd_byte  = 0;
  int unsigned rd_bits  = 8;   // bits still unread in the current byte

  int n_queued   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_too_long = 0;
  int n_errors   = 0;

  cmd_t                  cmd_q[$];      // commands waiting to go out
  logic [OUT_DATA_W-1:0] result_q[$];   // predicted results, oldest first

  // Consume one bit MSB first. Past the fill length the bit reads as zero, and at
  // the end of the store the position stops moving.
  function automatic bit pull_bit();
    bit b;
    b = 1'b0;
    if (rd_byte >= DEPTH) return 1'b0;
    if (rd_bits == 0 || rd_bits > 8) rd_bits = 8;
    rd_bits--;
    if (rd_byte < buf_len) b = rbsp_mem[rd_byte][rd_bits];
    if (rd_bits == 0) begin
      rd_byte++;
      rd_bits = 8;
    end
    return b;
  endfunction

  function automatic logic [31:0] pull_bits(int unsigned n);
    logic [31:0] r;
    r = '0;
    for (int unsigned i = 0; i < n; i++) r = {r[30:0], pull_bit()};
    return r;
  endfunction

  // Decode ue(v). The prefix ends on a one, on running off the data, or once a
  // further bit has been read after 32 zeros. A 32-zero prefix saturates.
  function automatic logic [31:0] decode_eg(output bit too_long);
    int unsigned zeros;
    logic [31:0] sfx;
    zeros    = 0;
    too_long = 1'b0;
    while (pull_bit() == 1'b0 && zeros < 32 && rd_byte < buf_len) zeros++;
    sfx = pull_bits(zeros);
    if (zeros >= 32) begin
      too_long = 1'b1;
      return '1;
    end
    return sfx + ((32'd1 << zeros) - 32'd1);
  endfunction

  // more_rbsp_data(): on the last byte, compare unread bits against the stop bit
  // plus the zeros after it (a zero byte counts all eight).
  function automatic bit rbsp_pending();
    logic [7:0]  last;
    int unsigned tail;
    if (buf_len == 0 || rd_byte >= buf_len) return 1'b0;
    if (rd_byte < buf_len - 1) return 1'b1;
    last = rbsp_mem[buf_len - 1];
    tail = 0;
    for (int i = 0; i < 8; i++) begin
      if (tail == 0 && last[i]) tail = i + 1;
    end
    if (tail == 0) tail = 8;
    return rd_bits > tail;
  endfunction

  // Apply one command to the mirror and build the result item it must produce.
  function automatic logic [OUT_DATA_W-1:0] predict(cmd_t c);
    logic [31:0] val;
    logic [31:0] k;
    bit          tl;
    int unsigned n;
    int unsigned keep_byte;
    int unsigned keep_bits;
    val = '0;
    tl  = 1'b0;
    n   = (c.cnt > MAX_BITS) ? 32 : c.cnt;
    case (c.kind)
      KIND_CLEAR: begin
        buf_len = 0;
        rd_byte = 0;
        rd_bits = 8;
      end
      KIND_APPEND: begin
        if (buf_len < DEPTH) begin
          rbsp_mem[buf_len] = c.data;
          buf_len++;
        end
      end
      KIND_READ: val = pull_bits(n);
      KIND_PEEK: begin
        keep_byte = rd_byte;
        keep_bits = rd_bits;
        val       = pull_bits(n);
        rd_byte   = keep_byte;
        rd_bits   = keep_bits;
      end
      KIND_SKIP: void'(pull_bits(n));
      KIND_UE: val = decode_eg(tl);
      KIND_SE: begin
        k   = decode_eg(tl);
        val = k[0] ? (k >> 1) + 32'd1 : 32'd0 - (k >> 1);
      end
      default: ;
    endcase
    if (tl) n_too_long++;
    return {4'b0000, tl, rd_byte >= buf_len, rd_bits == 8, rbsp_pending(), val};
  endfunction

  // Idle length for either side: mostly none, sometimes a few cycles, rarely long.
  // A quiet stretch gives none at all.
  function automatic int idle_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: present the next queued item, hold it until accepted, then idle for
  // a random gap. in_tvalid gets one assignment per edge at most.
  // ---------------------------------------------------------------------------
  cmd_t cur_cmd;
  int   tx_gap     = 0;
  int   tx_stretch = 0;
  bit   tx_quiet   = 1'b0;

  always @(posedge clk) begin : sender
    logic [OUT_DATA_W-1:0] want;
    if (tx_stretch == 0) begin
      tx_quiet   = ($urandom_range(0, 3) == 0);
      tx_stretch = $urandom_range(20, 200);
    end else begin
      tx_stretch--;
    end
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = predict(cur_cmd);
        if (cur_cmd.fixed) want = cur_cmd.res;
        result_q.push_back(want);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd    = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, cur_cmd.cnt, cur_cmd.data};
          in_tuser  <= cur_cmd.kind;
          tx_gap     = idle_len(tx_quiet);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall at random, compare every accepted result with the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  int rx_hold    = 0;
  int rx_stretch = 0;
  bit rx_quiet   = 1'b0;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t ns: result %0d %s: expected %h, got %h",
               $time, n_results, name, want, got);
    end
  endtask

  always @(posedge clk) begin : receiver
    logic [OUT_DATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        n_errors++;
        $display("%0t ns: result with nothing pending: expected none, got %h",
                 $time, out_tdata);
      end else begin
        want = result_q.pop_front();
        check_field("value", want[31:0], out_tdata[31:0]);
        check_field("more_rbsp", 32'(want[32]), 32'(out_tdata[32]));
        check_field("aligned", 32'(want[33]), 32'(out_tdata[33]));
        check_field("at_end", 32'(want[34]), 32'(out_tdata[34]));
        check_field("code_too_long", 32'(want[35]), 32'(out_tdata[35]));
        check_field("pad", 32'(want[39:36]), 32'(out_tdata[39:36]));
        n_results++;
      end
    end
    if (rx_stretch == 0) begin
      rx_quiet   = ($urandom_range(0, 3) == 0);
      rx_stretch = $urandom_range(20, 200);
    end else begin
      rx_stretch--;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      rx_hold = idle_len(rx_quiet);
      out_tready <= (rx_hold == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Queue one command; hold while the backlog is deep.
  task automatic queue_cmd(kind_t k, logic [7:0] b, logic [5:0] n, bit fixed = 1'b0,
                           logic [OUT_DATA_W-1:0] res = '0);
    cmd_t c;
    c = '{k, b, n, fixed, res};
    while (cmd_q.size() >= 64) @(posedge clk);
    cmd_q.push_back(c);
    n_queued++;
  endtask

  // Hold the sender until every queued item was accepted and every result came back.
  task automatic wait_idle();
    while (n_accepted != n_queued || result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Directed items. Typed results: empty buffer, first byte, over-long se code and
  // the status after it. Rows with fixed = 0 go to the predictor.
  cmd_t dir_tab [24] = '{
    '{KIND_STATUS, 8'h00, 6'd0,  1'b1, 40'h06_0000_0000},  // empty after reset
    '{KIND_READ,   8'h00, 6'd32, 1'b1, 40'h06_0000_0000},  // read from empty buffer
    '{KIND_CLEAR,  8'h00, 6'd0,  1'b1, 40'h06_0000_0000},
    '{KIND_APPEND, 8'hFF, 6'd0,  1'b1, 40'h03_0000_0000},
    '{KIND_APPEND, 8'h00, 6'd0,  1'b0, '0},
    '{KIND_APPEND, 8'h80, 6'd0,  1'b0, '0},
    '{KIND_APPEND, 8'h01, 6'd0,  1'b0, '0},
    '{KIND_PEEK,   8'h00, 6'd63, 1'b0, '0},                // count saturates to 32
    '{KIND_READ,   8'h00, 6'd0,  1'b0, '0},
    '{KIND_READ,   8'h00, 6'd1,  1'b0, '0},
    '{KIND_UE,     8'h00, 6'd0,  1'b0, '0},
    '{KIND_SE,     8'h00, 6'd0,  1'b0, '0},
    '{KIND_SKIP,   8'h00, 6'd5,  1'b0, '0},
    '{KIND_STATUS, 8'h00, 6'd0,  1'b0, '0},
    '{KIND_READ,   8'h00, 6'd33, 1'b0, '0},                // runs past the data
    '{KIND_CLEAR,  8'h00, 6'd0,  1'b1, 40'h06_0000_0000},
    '{KIND_APPEND, 8'h00, 6'd0,  1'b0, '0},
    '{KIND_APPEND, 8'h00, 6'd0,  1'b0, '0},
    '{KIND_APPEND, 8'h00, 6'd0,  1'b0, '0},
    '{KIND_APPEND, 8'h00, 6'd0,  1'b0, '0},
    '{KIND_APPEND, 8'h00, 6'd0,  1'b0, '0},
    '{KIND_SE,     8'h00, 6'd0,  1'b1, 40'h0C_8000_0000},  // 32-zero prefix
    '{KIND_STATUS, 8'hFF, 6'd63, 1'b1, 40'h04_0000_0000},  // unused fields all ones
    '{KIND_CLEAR,  8'h00, 6'd0,  1'b1, 40'h06_0000_0000}
  };

  // Well-formed slice-header-like frame: a string of ue/se codes and fixed fields,
  // closed by the RBSP stop bit, loaded byte by byte and then parsed in order.
  task automatic encoded_frame();
    bit         fb[$];
    cmd_t       ops[$];
    logic [7:0] by;
    logic [63:0] sfx;
    logic [5:0] cnt;
    kind_t      k;
    int         n_el;
    int         sel;
    int         len;
    int         r;
    n_el = $urandom_range(1, 8);
    repeat (n_el) begin
      sel = $urandom_range(0, 99);
      cnt = '0;
      if (sel < 50) begin
        k   = (sel < 28) ? KIND_UE : KIND_SE;
        r   = $urandom_range(0, 99);
        len = (r < 70) ? $urandom_range(0, 4) :
              (r < 92) ? $urandom_range(5, 15) : $urandom_range(16, 31);
        sfx = {$urandom, $urandom};
        repeat (len) fb.push_back(1'b0);
        fb.push_back(1'b1);
        for (int i = len - 1; i >= 0; i--) fb.push_back(sfx[i]);
      end else if (sel < 56) begin
        // over-long prefix: 32 zeros, one more bit, 32 suffix bits
        k = ($urandom_range(0, 1) == 0) ? KIND_UE : KIND_SE;
        repeat (32) fb.push_back(1'b0);
        repeat (33) fb.push_back(1'($urandom));
      end else if (sel < 80) begin
        k   = (sel < 72) ? KIND_READ : KIND_SKIP;
        len = $urandom_range(0, 32);
        repeat (len) fb.push_back(1'($urandom));
        cnt = 6'(len);
        if (len == 32 && $urandom_range(0, 1) == 1) cnt = 6'($urandom_range(33, 63));
      end else if (sel < 90) begin
        k   = KIND_PEEK;
        cnt = 6'($urandom_range(0, 63));
      end else begin
        k = KIND_STATUS;
      end
      ops.push_back('{k, 8'h00, cnt, 1'b0, '0});
    end
    // stop bit, zero fill to the byte boundary, now and then a trailing zero byte
    fb.push_back(1'b1);
    while (fb.size() % 8 != 0) fb.push_back(1'b0);
    if ($urandom_range(0, 9) == 0) repeat (8) fb.push_back(1'b0);

    queue_cmd(KIND_CLEAR, 8'($urandom), 6'($urandom));
    while (fb.size() > 0) begin
      by = '0;
      for (int i = 0; i < 8; i++) by = {by[6:0], fb.pop_front()};
      queue_cmd(KIND_APPEND, by, 6'($urandom));
    end
    foreach (ops[i]) begin
      if ($urandom_range(0, 4) == 0) queue_cmd(KIND_STATUS, 8'($urandom), 6'($urandom));
      queue_cmd(ops[i].kind, 8'($urandom), ops[i].cnt);
    end
    // sometimes keep reading past the stop bit and off the end
    if ($urandom_range(0, 3) == 0)
      queue_cmd(kind_t'($urandom_range(2, 6)), 8'($urandom), 6'($urandom_range(0, 63)));
  endtask

  // Noise: random bytes heavy in zeros, random kinds and counts, no guaranteed clear.
  task automatic loose_frame();
    logic [7:0] by;
    kind_t      k;
    int         nb;
    int         nops;
    int         r;
    if ($urandom_range(0, 4) != 0) queue_cmd(KIND_CLEAR, 8'($urandom), 6'($urandom));
    nb = $urandom_range(0, 10);
    repeat (nb) begin
      r  = $urandom_range(0, 99);
      by = (r < 40) ? 8'h00 : (r < 55) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom);
      queue_cmd(KIND_APPEND, by, 6'($urandom));
    end
    nops = $urandom_range(1, 10);
    repeat (nops) begin
      r = $urandom_range(0, 99);
      k = (r < 5) ? KIND_CLEAR : (r < 15) ? KIND_APPEND : kind_t'($urandom_range(2, 7));
      queue_cmd(k, 8'($urandom),
                ($urandom_range(0, 4) == 0) ? 6'($urandom_range(33, 63))
                                            : 6'($urandom_range(0, 32)));
    end
  endtask

  initial begin : stimulus
    int  rand_start;
    bit  paused;
    paused = 1'b0;

    foreach (dir_tab[i])
      queue_cmd(dir_tab[i].kind, dir_tab[i].data, dir_tab[i].cnt,
                dir_tab[i].fixed, dir_tab[i].res);
    wait_idle();

    // Random part, mostly well-formed frames. Halfway through, hold the sender
    // until the result side has fully drained.
    rand_start = n_queued;
    while (n_queued - rand_start < RAND_ITEMS) begin
      if (!paused && n_queued - rand_start >= RAND_ITEMS / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) encoded_frame();
      else loose_frame();
    end
    wait_idle();
    repeat (40) @(posedge clk);  // catch stray results after the last one

    if (result_q.size() != 0) begin
      n_errors++;
      $display("%0t ns: results missing at the end: expected %0d more, got none",
               $time, result_q.size());
    end

    $display("Checked %0d results for %0d items, %0d of them over-long Exp-Golomb codes;",
             n_results, n_accepted, n_too_long);
    $display("covered all kinds, RBSP frames, noisy buffers and reads off the data end.");
    if (n_errors == 0) begin
      $display("[exp_golomb_bit_reader_top] OK");
    end else begin
      $display("[exp_golomb_bit_reader_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/egbr_pkg.sv
src/egbr_ram.sv
src/exp_golomb_bit_reader_top.sv
src/egbr_checker.sv
tb/tb.sv
